// ----- hdl/cbq_pkg.sv -----
package cbq_pkg;

	localparam int NUM_CHANNELS = 2;
	localparam int MAX_STAGES   = 4;

	localparam int SMP_W     = 24;
	localparam int CH_W      = 1;
	localparam int COEF_W    = 32;
	localparam int SLOPE_W   = 2;
	localparam int DLY_W     = 40;
	localparam int PROD_W    = COEF_W + SMP_W;
	localparam int ACC_W     = 64;
	localparam int ALIGN_SH  = 21;
	localparam int OUT_SH    = 28;
	localparam int REG_IDX_W = 3;

	localparam int DEPTH     = NUM_CHANNELS * MAX_STAGES;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int STG_W     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int STG_CNT_W = $clog2(MAX_STAGES + 1);

	localparam logic [REG_IDX_W-1:0] REG_B0    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_B1    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_B2    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_A1    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_A2    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SLOPE = 3'd5;

	localparam logic [SLOPE_W-1:0] SLOPE_ONE   = 2'd0;
	localparam logic [SLOPE_W-1:0] SLOPE_TWO   = 2'd1;
	localparam logic [SLOPE_W-1:0] SLOPE_FOUR  = 2'd2;
	localparam logic [SLOPE_W-1:0] SLOPE_SPARE = 2'd3;

	localparam logic [2:0] CSEL_B0 = 3'd0;
	localparam logic [2:0] CSEL_B1 = 3'd1;
	localparam logic [2:0] CSEL_B2 = 3'd2;
	localparam logic [2:0] CSEL_A1 = 3'd3;
	localparam logic [2:0] CSEL_A2 = 3'd4;

	localparam logic [1:0] BASE_ACC  = 2'd0;
	localparam logic [1:0] BASE_Z1   = 2'd1;
	localparam logic [1:0] BASE_Z2   = 2'd2;
	localparam logic [1:0] BASE_ZERO = 2'd3;

	localparam logic [1:0] AOP_NONE = 2'd0;
	localparam logic [1:0] AOP_ADD  = 2'd1;
	localparam logic [1:0] AOP_SUB  = 2'd2;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

	typedef struct packed {
		logic             load_x;
		logic             clr_y;
		logic             y_en;
		logic             adv;
		logic             mul_en;
		logic [2:0]       mul_coef;
		logic             mul_sel_y;
		logic             acc_en;
		logic [1:0]       acc_base;
		logic [1:0]       acc_op;
		logic             wr_first;
		logic             wr_second;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	function automatic logic [STG_CNT_W-1:0] stage_count(input logic [SLOPE_W-1:0] slope);
		int n;
		case (slope)
			SLOPE_ONE: n = 1;
			SLOPE_TWO: n = 2;
			default:   n = 4;
		endcase
		if (n > MAX_STAGES)
			n = MAX_STAGES;
		return STG_CNT_W'(n);
	endfunction

endpackage

// ----- hdl/cbq_ctrl.sv -----
module cbq_ctrl
	import cbq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CH_W-1:0]      in_channel,
	input  logic [SLOPE_W-1:0]   slope,
	input  logic                 out_free,
	output logic                 done,
	output cmd_t                 cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_C0   = 4'd1;
	localparam logic [3:0] ST_C1   = 4'd2;
	localparam logic [3:0] ST_C2   = 4'd3;
	localparam logic [3:0] ST_C3   = 4'd4;
	localparam logic [3:0] ST_C4   = 4'd5;
	localparam logic [3:0] ST_C5   = 4'd6;
	localparam logic [3:0] ST_C6   = 4'd7;
	localparam logic [3:0] ST_C7   = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;

	logic [3:0]           state_q;
	logic [3:0]           state_d;
	logic [CH_W-1:0]      ch_q;
	logic [STG_W-1:0]     stage_q;
	logic [STG_CNT_W-1:0] nst_q;
	logic                 accept;
	logic                 ch_ok;
	logic                 last_stage;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign ch_ok      = (int'(in_channel) < NUM_CHANNELS);
	assign last_stage = ((int'(stage_q) + 1) >= int'(nst_q));
	assign done       = (state_q == ST_FIN) && out_free;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.idx = IDX_W'(int'(ch_q) * MAX_STAGES + int'(stage_q));
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_x = 1'b1;
					cmd.clr_y  = !ch_ok;
					state_d    = ch_ok ? ST_C0 : ST_FIN;
				end
			end
			ST_C0: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_coef = CSEL_B0;
				state_d      = ST_C1;
			end
			ST_C1: begin
				cmd.acc_en   = 1'b1;
				cmd.acc_base = BASE_Z1;
				cmd.acc_op   = AOP_ADD;
				cmd.mul_en   = 1'b1;
				cmd.mul_coef = CSEL_B1;
				state_d      = ST_C2;
			end
			ST_C2: begin
				cmd.y_en     = 1'b1;
				cmd.acc_en   = 1'b1;
				cmd.acc_base = BASE_Z2;
				cmd.acc_op   = AOP_ADD;
				state_d      = ST_C3;
			end
			ST_C3: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_coef  = CSEL_A1;
				cmd.mul_sel_y = 1'b1;
				state_d       = ST_C4;
			end
			ST_C4: begin
				cmd.acc_en   = 1'b1;
				cmd.acc_base = BASE_ACC;
				cmd.acc_op   = AOP_SUB;
				cmd.mul_en   = 1'b1;
				cmd.mul_coef = CSEL_B2;
				state_d      = ST_C5;
			end
			ST_C5: begin
				cmd.wr_first  = 1'b1;
				cmd.acc_en    = 1'b1;
				cmd.acc_base  = BASE_ZERO;
				cmd.acc_op    = AOP_ADD;
				cmd.mul_en    = 1'b1;
				cmd.mul_coef  = CSEL_A2;
				cmd.mul_sel_y = 1'b1;
				state_d       = ST_C6;
			end
			ST_C6: begin
				cmd.acc_en   = 1'b1;
				cmd.acc_base = BASE_ACC;
				cmd.acc_op   = AOP_SUB;
				state_d      = ST_C7;
			end
			ST_C7: begin
				cmd.wr_second = 1'b1;
				cmd.adv       = 1'b1;
				state_d       = last_stage ? ST_FIN : ST_C0;
			end
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			stage_q <= '0;
			nst_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				ch_q    <= in_channel;
				stage_q <= '0;
				nst_q   <= stage_count(slope);
			end else if (state_q == ST_C7 && !last_stage) begin
				stage_q <= stage_q + 1'b1;
			end
		end
	end

endmodule

// ----- hdl/cbq_datapath.sv -----
module cbq_datapath
	import cbq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  coef_t                   coef,
	input  logic signed [SMP_W-1:0] in_sample,
	output logic signed [SMP_W-1:0] y
);

	localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(64'sd1 <<< (OUT_SH - 1));
	localparam logic signed [ACC_W-1:0] D_HALF = ACC_W'(64'sd1 <<< (ALIGN_SH - 1));
	localparam logic signed [ACC_W-1:0] Y_MAX  = ACC_W'((64'sd1 <<< (SMP_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] Y_MIN  = -Y_MAX - 1;
	localparam logic signed [ACC_W-1:0] D_MAX  = ACC_W'((64'sd1 <<< (DLY_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] D_MIN  = -D_MAX - 1;

	logic signed [SMP_W-1:0]  x_q;
	logic signed [SMP_W-1:0]  y_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DLY_W-1:0]  dly1_q [DEPTH];
	logic signed [DLY_W-1:0]  dly2_q [DEPTH];

	logic signed [COEF_W-1:0] mul_a;
	logic signed [SMP_W-1:0]  mul_b;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  acc_d;
	logic signed [ACC_W-1:0]  y_rnd;
	logic signed [ACC_W-1:0]  d_rnd;
	logic signed [SMP_W-1:0]  y_sat;
	logic signed [DLY_W-1:0]  d_sat;

	always_comb begin
		case (cmd.mul_coef)
			CSEL_B0: mul_a = coef.b0;
			CSEL_B1: mul_a = coef.b1;
			CSEL_B2: mul_a = coef.b2;
			CSEL_A1: mul_a = coef.a1;
			CSEL_A2: mul_a = coef.a2;
			default: mul_a = '0;
		endcase
		mul_b = cmd.mul_sel_y ? y_q : x_q;
	end

	always_comb begin
		case (cmd.acc_base)
			BASE_ACC:  base = acc_q;
			BASE_Z1:   base = ACC_W'(dly1_q[cmd.idx]) <<< ALIGN_SH;
			BASE_Z2:   base = ACC_W'(dly2_q[cmd.idx]) <<< ALIGN_SH;
			default:   base = '0;
		endcase
		prod_ext = ACC_W'(prod_q);
		case (cmd.acc_op)
			AOP_ADD: acc_d = base + prod_ext;
			AOP_SUB: acc_d = base - prod_ext;
			default: acc_d = base;
		endcase
	end

	// round half up, then saturate
	always_comb begin
		y_rnd = (acc_q + Y_HALF) >>> OUT_SH;
		d_rnd = (acc_q + D_HALF) >>> ALIGN_SH;
		if (y_rnd > Y_MAX)
			y_sat = Y_MAX[SMP_W-1:0];
		else if (y_rnd < Y_MIN)
			y_sat = Y_MIN[SMP_W-1:0];
		else
			y_sat = y_rnd[SMP_W-1:0];
		if (d_rnd > D_MAX)
			d_sat = D_MAX[DLY_W-1:0];
		else if (d_rnd < D_MIN)
			d_sat = D_MIN[DLY_W-1:0];
		else
			d_sat = d_rnd[DLY_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x)
			x_q <= in_sample;
		else if (cmd.adv)
			x_q <= y_q;
		if (cmd.clr_y)
			y_q <= '0;
		else if (cmd.y_en)
			y_q <= y_sat;
		if (cmd.mul_en)
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (cmd.acc_en)
			acc_q <= acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				dly1_q[i] <= '0;
				dly2_q[i] <= '0;
			end
		end else begin
			if (cmd.wr_first)
				dly1_q[cmd.idx] <= d_sat;
			if (cmd.wr_second)
				dly2_q[cmd.idx] <= d_sat;
		end
	end

	assign y = y_q;

endmodule

// ----- hdl/cascaded_biquad_filter_unit.sv -----
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: sample_in; tuser: channel
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: sample_out
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// One shared 32x24 multiplier and accumulator; each stage steps through C0 to C7.
// A sample is loaded, then runs one, two or four stages set by the slope register.
// A new sample is taken once the previous one has reached the output register.
// Reset clears coefficients to their defaults and all delay words to zero.
// cfg_ready is always high.
module cascaded_biquad_filter_unit
	import cbq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,   // [23:0] sample_in
	input  logic [0:0]           s_axis_tuser,   // [0] channel
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,   // [23:0] sample_out
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	coef_t                   coef_q;
	logic [SLOPE_W-1:0]      slope_q;
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] out_q;
	logic                    out_free;
	logic                    done;
	logic signed [SMP_W-1:0] y;
	cmd_t                    cmd;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= COEF_W'(32'sd268435456);
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
			slope_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_B0:    coef_q.b0 <= cfg_data;
				REG_B1:    coef_q.b1 <= cfg_data;
				REG_B2:    coef_q.b2 <= cfg_data;
				REG_A1:    coef_q.a1 <= cfg_data;
				REG_A2:    coef_q.a2 <= cfg_data;
				REG_SLOPE: slope_q   <= cfg_data[SLOPE_W-1:0];
				default:   ;
			endcase
		end
	end

	cbq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_channel (s_axis_tuser[0]),
		.slope      (slope_q),
		.out_free   (out_free),
		.done       (done),
		.cmd        (cmd)
	);

	cbq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.coef      (coef_q),
		.in_sample (s_axis_tdata[SMP_W-1:0]),
		.y         (y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			out_q <= y;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule
